// ----- sv/lbps_pkg.sv -----
// Package for the positive-direction streaming block of the D3Q19 solver.
// Holds sizes, store depths, shared types and register indexes.
// Depends on nothing else.
`default_nettype none

package lbps_pkg;

   // Build-time limits of the lattice and the population word.
   localparam int MAX_ROW_NODES  = 64;
   localparam int MAX_PLANE_ROWS = 64;
   localparam int WORD_BITS      = 64;

   // Largest interior count that a size register may hold.
   localparam int ROW_LIMIT   = (MAX_ROW_NODES - 2 < 62) ? MAX_ROW_NODES - 2 : 62;
   localparam int PLANE_LIMIT = (MAX_PLANE_ROWS - 2 < 62) ? MAX_PLANE_ROWS - 2 : 62;

   // Depths of the delay stores, one for each lane that needs a store.
   localparam int PLANE_CAP = MAX_ROW_NODES * MAX_PLANE_ROWS;
   localparam int CAP_X     = PLANE_CAP;
   localparam int CAP_XY    = PLANE_CAP + MAX_ROW_NODES;
   localparam int CAP_XZ    = PLANE_CAP + 1;
   localparam int CAP_Y     = MAX_ROW_NODES;
   localparam int CAP_YZ    = MAX_ROW_NODES + 1;

   localparam int X_ADDR_BITS  = $clog2(CAP_X);
   localparam int XY_ADDR_BITS = $clog2(CAP_XY);
   localparam int XZ_ADDR_BITS = $clog2(CAP_XZ);
   localparam int Y_ADDR_BITS  = $clog2(CAP_Y);
   localparam int YZ_ADDR_BITS = $clog2(CAP_YZ);

   // Wide enough for a pointer plus the largest depth.
   localparam int DLY_BITS = $clog2(2 * CAP_XY);

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;
   localparam int SIZE_BITS      = 6;
   localparam int IEND_BITS      = 12;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROWS_PER_PLANE = 3'd0,
      CSR_NODES_PER_ROW  = 3'd1,
      CSR_X_END          = 3'd2,
      CSR_Y_END          = 3'd3,
      CSR_Z_END          = 3'd4
   } csr_index_type;

   typedef logic [WORD_BITS-1:0] word_type;

   // The six populations that one node carries.
   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
      word_type xy;
      word_type xz;
      word_type yz;
   } pop_set_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] rows_per_plane;
      logic [SIZE_BITS-1:0] nodes_per_row;
      logic [IEND_BITS-1:0] x_end;
      logic [SIZE_BITS-1:0] y_end;
      logic [SIZE_BITS-1:0] z_end;
   } cfg_type;

   // Pipeline handshake between the control in the top level and the stages.
   typedef struct packed {
      logic accept;
      logic advance;
   } pipe_ctrl_type;

   // Saturate a size register to the range one up to its limit.
   function automatic logic [SIZE_BITS-1:0] clamp_size(logic [SIZE_BITS-1:0] v, int limit);
      logic [SIZE_BITS-1:0] res;
      if (v == '0) begin
         res = SIZE_BITS'(1);
      end else if (int'(v) > limit) begin
         res = SIZE_BITS'(limit);
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- sv/lbps_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Read-first: a read of the address being written returns the old word.
// No dependencies.
`default_nettype none

module lbps_ram #(
   parameter int DEPTH     = 64,
   parameter int ADDR_BITS = 6,
   parameter int DATA_BITS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];

   // Storage array with the read data held until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/lbps_pos.sv -----
// Raster position tracker and interior window test for the streaming block.
// Uses lbps_pkg for the configuration struct and the handshake struct.
`default_nettype none

module lbps_pos (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lbps_pkg::pipe_ctrl_type ctrl,
   input  wire logic                   frame_start,
   input  wire lbps_pkg::cfg_type      cfg,
   output logic                        inside_ff
);
   import lbps_pkg::*;

   logic [IEND_BITS-1:0] pos_i_ff, pos_i_in, cur_i;
   logic [SIZE_BITS-1:0] pos_j_ff, pos_j_in, cur_j;
   logic [SIZE_BITS-1:0] pos_k_ff, pos_k_in, cur_k;
   logic [SIZE_BITS:0]   last_k, last_j;
   logic                 inside_in;

   // A frame start puts the word at the lattice origin.
   assign cur_i = frame_start ? '0 : pos_i_ff;
   assign cur_j = frame_start ? '0 : pos_j_ff;
   assign cur_k = frame_start ? '0 : pos_k_ff;

   assign last_k = {1'b0, cfg.nodes_per_row} + 1'b1;
   assign last_j = {1'b0, cfg.rows_per_plane} + 1'b1;

   // The window covers one up to the end register along each axis.
   assign inside_in = (cur_i != '0) && (cur_i <= cfg.x_end) &&
                      (cur_j != '0) && (cur_j <= cfg.y_end) &&
                      (cur_k != '0) && (cur_k <= cfg.z_end);

   // Advance k, then j, then i; k and j wrap at the last halo index.
   always_comb begin
      pos_i_in = cur_i;
      pos_j_in = cur_j;
      pos_k_in = cur_k;
      if ({1'b0, cur_k} >= last_k) begin
         pos_k_in = '0;
         if ({1'b0, cur_j} >= last_j) begin
            pos_j_in = '0;
            pos_i_in = cur_i + 1'b1;
         end else begin
            pos_j_in = cur_j + 1'b1;
         end
      end else begin
         pos_k_in = cur_k + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_i_ff  <= '0;
         pos_j_ff  <= '0;
         pos_k_ff  <= '0;
         inside_ff <= 1'b0;
      end else if (ctrl.accept) begin
         pos_i_ff  <= pos_i_in;
         pos_j_ff  <= pos_j_in;
         pos_k_ff  <= pos_k_in;
         inside_ff <= inside_in;
      end
   end

   // The node after a frame start is the second node of the first row.
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept && frame_start |=>
         pos_i_ff == '0 && pos_j_ff == '0 && pos_k_ff == SIZE_BITS'(1))
      else $error("position did not restart at a frame start");

endmodule

`default_nettype wire

// ----- sv/lbps_lanes.sv -----
// Six population lanes side by side; five have their own delay store, the z lane a register.
// Uses lbps_pkg and instantiates lbps_ram for the five stored lanes.
`default_nettype none

module lbps_lanes (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lbps_pkg::pipe_ctrl_type ctrl,
   input  wire lbps_pkg::cfg_type       cfg,
   input  wire lbps_pkg::pop_set_type   pop,
   output lbps_pkg::pop_set_type        old_set,
   output lbps_pkg::pop_set_type        pass_set
);
   import lbps_pkg::*;

   logic [X_ADDR_BITS-1:0]  wp_x_ff,  wp_x_in;
   logic [XY_ADDR_BITS-1:0] wp_xy_ff, wp_xy_in;
   logic [XZ_ADDR_BITS-1:0] wp_xz_ff, wp_xz_in;
   logic [Y_ADDR_BITS-1:0]  wp_y_ff,  wp_y_in;
   logic [YZ_ADDR_BITS-1:0] wp_yz_ff, wp_yz_in;

   logic [DLY_BITS-1:0] row_len, plane_rows, plane_len;
   logic [DLY_BITS-1:0] d_x, d_xy, d_xz, d_y, d_yz;
   logic [DLY_BITS-1:0] ra_x, ra_xy, ra_xz, ra_y, ra_yz;

   word_type    prev_z_ff, z_old_ff;
   pop_set_type pass_ff;

   // Index of the word written a given number of nodes ago in a circular store.
   function automatic logic [DLY_BITS-1:0] back_index(logic [DLY_BITS-1:0] wp,
                                                      logic [DLY_BITS-1:0] dly,
                                                      logic [DLY_BITS-1:0] cap);
      logic [DLY_BITS-1:0] res;
      if (wp >= dly) begin
         res = wp - dly;
      end else begin
         res = wp + cap - dly;
      end
      return res;
   endfunction

   // Lattice row and plane lengths, halo included, give the lane delays.
   assign row_len    = DLY_BITS'(cfg.nodes_per_row) + DLY_BITS'(2);
   assign plane_rows = DLY_BITS'(cfg.rows_per_plane) + DLY_BITS'(2);
   assign plane_len  = row_len * plane_rows;

   assign d_x  = plane_len;
   assign d_xy = plane_len + row_len;
   assign d_xz = plane_len + DLY_BITS'(1);
   assign d_y  = row_len;
   assign d_yz = row_len + DLY_BITS'(1);

   assign ra_x  = back_index(DLY_BITS'(wp_x_ff),  d_x,  DLY_BITS'(CAP_X));
   assign ra_xy = back_index(DLY_BITS'(wp_xy_ff), d_xy, DLY_BITS'(CAP_XY));
   assign ra_xz = back_index(DLY_BITS'(wp_xz_ff), d_xz, DLY_BITS'(CAP_XZ));
   assign ra_y  = back_index(DLY_BITS'(wp_y_ff),  d_y,  DLY_BITS'(CAP_Y));
   assign ra_yz = back_index(DLY_BITS'(wp_yz_ff), d_yz, DLY_BITS'(CAP_YZ));

   // Write pointers step once per accepted word and wrap at the store depth.
   assign wp_x_in  = (wp_x_ff  == X_ADDR_BITS'(CAP_X - 1))   ? '0 : wp_x_ff  + 1'b1;
   assign wp_xy_in = (wp_xy_ff == XY_ADDR_BITS'(CAP_XY - 1)) ? '0 : wp_xy_ff + 1'b1;
   assign wp_xz_in = (wp_xz_ff == XZ_ADDR_BITS'(CAP_XZ - 1)) ? '0 : wp_xz_ff + 1'b1;
   assign wp_y_in  = (wp_y_ff  == Y_ADDR_BITS'(CAP_Y - 1))   ? '0 : wp_y_ff  + 1'b1;
   assign wp_yz_in = (wp_yz_ff == YZ_ADDR_BITS'(CAP_YZ - 1)) ? '0 : wp_yz_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_x_ff  <= '0;
         wp_xy_ff <= '0;
         wp_xz_ff <= '0;
         wp_y_ff  <= '0;
         wp_yz_ff <= '0;
      end else if (ctrl.accept) begin
         wp_x_ff  <= wp_x_in;
         wp_xy_ff <= wp_xy_in;
         wp_xz_ff <= wp_xz_in;
         wp_y_ff  <= wp_y_in;
         wp_yz_ff <= wp_yz_in;
      end
   end

   // The z lane needs only the previous node, and every lane keeps its input word.
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         z_old_ff  <= prev_z_ff;
         prev_z_ff <= pop.z;
         pass_ff   <= pop;
      end
   end

   lbps_ram #(.DEPTH(CAP_X), .ADDR_BITS(X_ADDR_BITS), .DATA_BITS(WORD_BITS)) u_ram_x (
      .clock   (clock),
      .wr_en   (ctrl.accept),
      .wr_addr (wp_x_ff),
      .wr_data (pop.x),
      .rd_en   (ctrl.accept),
      .rd_addr (ra_x[X_ADDR_BITS-1:0]),
      .rd_data (old_set.x)
   );

   lbps_ram #(.DEPTH(CAP_XY), .ADDR_BITS(XY_ADDR_BITS), .DATA_BITS(WORD_BITS)) u_ram_xy (
      .clock   (clock),
      .wr_en   (ctrl.accept),
      .wr_addr (wp_xy_ff),
      .wr_data (pop.xy),
      .rd_en   (ctrl.accept),
      .rd_addr (ra_xy[XY_ADDR_BITS-1:0]),
      .rd_data (old_set.xy)
   );

   lbps_ram #(.DEPTH(CAP_XZ), .ADDR_BITS(XZ_ADDR_BITS), .DATA_BITS(WORD_BITS)) u_ram_xz (
      .clock   (clock),
      .wr_en   (ctrl.accept),
      .wr_addr (wp_xz_ff),
      .wr_data (pop.xz),
      .rd_en   (ctrl.accept),
      .rd_addr (ra_xz[XZ_ADDR_BITS-1:0]),
      .rd_data (old_set.xz)
   );

   lbps_ram #(.DEPTH(CAP_Y), .ADDR_BITS(Y_ADDR_BITS), .DATA_BITS(WORD_BITS)) u_ram_y (
      .clock   (clock),
      .wr_en   (ctrl.accept),
      .wr_addr (wp_y_ff),
      .wr_data (pop.y),
      .rd_en   (ctrl.accept),
      .rd_addr (ra_y[Y_ADDR_BITS-1:0]),
      .rd_data (old_set.y)
   );

   lbps_ram #(.DEPTH(CAP_YZ), .ADDR_BITS(YZ_ADDR_BITS), .DATA_BITS(WORD_BITS)) u_ram_yz (
      .clock   (clock),
      .wr_en   (ctrl.accept),
      .wr_addr (wp_yz_ff),
      .wr_data (pop.yz),
      .rd_en   (ctrl.accept),
      .rd_addr (ra_yz[YZ_ADDR_BITS-1:0]),
      .rd_data (old_set.yz)
   );

   assign old_set.z = z_old_ff;
   assign pass_set  = pass_ff;

endmodule

`default_nettype wire

// ----- sv/lbps_merge.sv -----
// Merging stage: picks the streamed or the incoming words for each lane.
// Uses lbps_pkg for the population set and the handshake struct.
`default_nettype none

module lbps_merge (
   input  wire logic                    clock,
   input  wire lbps_pkg::pipe_ctrl_type ctrl,
   input  wire logic                    in_window,
   input  wire lbps_pkg::pop_set_type   old_set,
   input  wire lbps_pkg::pop_set_type   pass_set,
   output logic                         node_updated_ff,
   output lbps_pkg::pop_set_type        out_set_ff
);
   import lbps_pkg::*;

   pop_set_type out_set_in;

   // Interior nodes take the upwind words; halo and outside nodes pass through.
   assign out_set_in = in_window ? old_set : pass_set;

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         node_updated_ff <= in_window;
         out_set_ff      <= out_set_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/lattice_boltzmann_positive_streaming.sv -----
// An accepted word passes the read stage and the output register before it is offered on rsp.
// Throughput: one node word per cycle while rsp is not stalled, set by one read and one write of each lane store.
// The five delay stores are read and written once per node by the lane RAM ports.
// Reset clears the write pointers, the position and the pipeline, and loads the
// registers with their defaults; the store contents stay undefined until written.
// Top level: uses lbps_pkg, lbps_pos, lbps_lanes and lbps_merge.
`default_nettype none

module lattice_boltzmann_positive_streaming (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_frame_start,
   input  wire logic [lbps_pkg::WORD_BITS-1:0]      req_pop_x,
   input  wire logic [lbps_pkg::WORD_BITS-1:0]      req_pop_y,
   input  wire logic [lbps_pkg::WORD_BITS-1:0]      req_pop_z,
   input  wire logic [lbps_pkg::WORD_BITS-1:0]      req_pop_xy,
   input  wire logic [lbps_pkg::WORD_BITS-1:0]      req_pop_xz,
   input  wire logic [lbps_pkg::WORD_BITS-1:0]      req_pop_yz,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_node_updated,
   output logic      [lbps_pkg::WORD_BITS-1:0]      rsp_new_x,
   output logic      [lbps_pkg::WORD_BITS-1:0]      rsp_new_y,
   output logic      [lbps_pkg::WORD_BITS-1:0]      rsp_new_z,
   output logic      [lbps_pkg::WORD_BITS-1:0]      rsp_new_xy,
   output logic      [lbps_pkg::WORD_BITS-1:0]      rsp_new_xz,
   output logic      [lbps_pkg::WORD_BITS-1:0]      rsp_new_yz,
   input  wire logic                                csr_wr_en,
   input  wire logic [lbps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lbps_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);
   import lbps_pkg::*;

   cfg_type       cfg_ff;
   pipe_ctrl_type ctrl;
   pop_set_type   pop, old_set, pass_set, out_set;
   logic          s1_valid_ff, s1_valid_in;
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_free, in_window;

   // Register file; sizes saturate on write, unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows_per_plane <= clamp_size(SIZE_BITS'(62), PLANE_LIMIT);
         cfg_ff.nodes_per_row  <= clamp_size(SIZE_BITS'(62), ROW_LIMIT);
         cfg_ff.x_end          <= IEND_BITS'(62);
         cfg_ff.y_end          <= SIZE_BITS'(62);
         cfg_ff.z_end          <= SIZE_BITS'(62);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS_PER_PLANE: begin
               cfg_ff.rows_per_plane <= clamp_size(csr_wr_data[SIZE_BITS-1:0], PLANE_LIMIT);
            end
            CSR_NODES_PER_ROW: begin
               cfg_ff.nodes_per_row <= clamp_size(csr_wr_data[SIZE_BITS-1:0], ROW_LIMIT);
            end
            CSR_X_END: begin
               cfg_ff.x_end <= csr_wr_data[IEND_BITS-1:0];
            end
            CSR_Y_END: begin
               cfg_ff.y_end <= csr_wr_data[SIZE_BITS-1:0];
            end
            CSR_Z_END: begin
               cfg_ff.z_end <= csr_wr_data[SIZE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Two-stage pipeline: store read stage, then the output register.
   assign s2_free      = !s2_valid_ff || !rsp_stall;
   assign ctrl.advance = s1_valid_ff && s2_free;
   assign req_stall    = s1_valid_ff && !s2_free;
   assign ctrl.accept  = req_valid && !req_stall;
   assign s1_valid_in  = ctrl.accept || (s1_valid_ff && !ctrl.advance);
   assign s2_valid_in  = ctrl.advance || (s2_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   assign pop.x  = req_pop_x;
   assign pop.y  = req_pop_y;
   assign pop.z  = req_pop_z;
   assign pop.xy = req_pop_xy;
   assign pop.xz = req_pop_xz;
   assign pop.yz = req_pop_yz;

   lbps_pos u_pos (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .frame_start (req_frame_start),
      .cfg         (cfg_ff),
      .inside_ff   (in_window)
   );

   lbps_lanes u_lanes (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cfg      (cfg_ff),
      .pop      (pop),
      .old_set  (old_set),
      .pass_set (pass_set)
   );

   lbps_merge u_merge (
      .clock           (clock),
      .ctrl            (ctrl),
      .in_window       (in_window),
      .old_set         (old_set),
      .pass_set        (pass_set),
      .node_updated_ff (rsp_node_updated),
      .out_set_ff      (out_set)
   );

   assign rsp_valid  = s2_valid_ff;
   assign rsp_new_x  = out_set.x;
   assign rsp_new_y  = out_set.y;
   assign rsp_new_z  = out_set.z;
   assign rsp_new_xy = out_set.xy;
   assign rsp_new_xz = out_set.xz;
   assign rsp_new_yz = out_set.yz;

   // The input side stalls only when both stages hold a word.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff)
      else $error("input stalled with a free pipeline stage");

   // An accepted word always occupies the read stage on the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept |=> s1_valid_ff)
      else $error("accepted word lost from the read stage");

   // A word in the read stage with an empty output register moves on at once.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_valid_ff |=> s2_valid_ff)
      else $error("read stage word did not reach the output register");

endmodule

`default_nettype wire
